// ===== src/toy_vm_execute_unit_top_macros.svh =====
// ----------------------------------------------------------------------------
// toy vm execute unit assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TOY_VM_EXECUTE_UNIT_TOP_MACROS_SVH
`define TOY_VM_EXECUTE_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define TVM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tvm_pkg.sv =====
// ----------------------------------------------------------------------------
// tvm_pkg
// beat types and opcodes for the toy vm execute unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvm_pkg;

    localparam int unsigned OP_W   = 4;
    localparam int unsigned ARG1_W = 16;
    localparam int unsigned ARG2_W = 32;
    localparam int unsigned ARG3_W = 4;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned NPC_W  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_HALT  = 4'd0,
        OP_NOP   = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_LOADI = 4'd4,
        OP_MOVE  = 4'd5,
        OP_JUMP  = 4'd6,
        OP_JNZ   = 4'd7,
        OP_JZ    = 4'd8,
        OP_PRINT = 4'd9
    } opcode_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ARG1_W-1:0]        first_arg;
        logic signed [ARG2_W-1:0] second_arg;
        logic [ARG3_W-1:0]        third_arg;
    } instr_t;

    typedef struct packed {
        logic [NPC_W-1:0]         next_pc;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic                     halted;
    } result_t;

endpackage

// ===== src/toy_vm_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// toy_vm_execute_unit_top
// in-order execute unit for a small register machine
// ----------------------------------------------------------------------------
// usage
//   instr channel (instr_valid / instr_ready / instr) takes one instruction
//   per beat; result channel (result_valid / result_ready / result) returns
//   one beat per instruction, in order
//   each beat passes the decode, execute and result registers in turn
//   throughput: one instruction per cycle; the register file read at the
//   decode-to-execute edge and the write in execute meet through a one-entry
//   forwarding register, so dependent instructions issue back to back
//   stall: when result_ready is low the result register holds, one more
//   instruction waits in execute and one in decode, then instr_ready drops
//   reset: registers read as zero (per-entry valid bits), counter zero,
//   not halted; the unit accepts instructions in the first cycle after reset
//   after a halt every instruction returns the held counter and halted set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module toy_vm_execute_unit_top
    import tvm_pkg::*;
#(
    parameter int unsigned REG_COUNT = 16,
    parameter int unsigned PC_WIDTH  = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    output logic    instr_ready,
    input  instr_t  instr,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int unsigned IDX_W = $clog2(REG_COUNT);

    // decode to execute
    logic              iss_valid;
    logic              iss_ready;
    instr_t            iss;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rd_a_idx;
    logic [IDX_W-1:0]  rd_b_idx;

    // register file ports
    logic [DATA_W-1:0] rf_a;
    logic [DATA_W-1:0] rf_b;
    logic              rf_we;
    logic [IDX_W-1:0]  rf_waddr;
    logic [DATA_W-1:0] rf_wdata;
    logic              rd_en;

    // operands are fetched as the instruction moves into execute
    assign rd_en = iss_valid && iss_ready;

    tvm_decode #(
        .REG_COUNT (REG_COUNT)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_valid (instr_valid),
        .instr_ready (instr_ready),
        .instr       (instr),
        .iss_valid   (iss_valid),
        .iss_ready   (iss_ready),
        .iss         (iss),
        .wr_idx      (wr_idx),
        .rd_a_idx    (rd_a_idx),
        .rd_b_idx    (rd_b_idx)
    );

    tvm_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_a_idx  (rd_a_idx),
        .rd_b_idx  (rd_b_idx),
        .rd_a_data (rf_a),
        .rd_b_data (rf_b),
        .wr_en     (rf_we),
        .wr_idx    (rf_waddr),
        .wr_data   (rf_wdata)
    );

    tvm_exec #(
        .REG_COUNT (REG_COUNT),
        .PC_WIDTH  (PC_WIDTH)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .iss_valid    (iss_valid),
        .iss_ready    (iss_ready),
        .iss          (iss),
        .wr_idx       (wr_idx),
        .rd_a_idx     (rd_a_idx),
        .rd_b_idx     (rd_b_idx),
        .rf_a         (rf_a),
        .rf_b         (rf_b),
        .rf_we        (rf_we),
        .rf_waddr     (rf_waddr),
        .rf_wdata     (rf_wdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== src/tvm_regfile.sv =====
// ----------------------------------------------------------------------------
// tvm_regfile
// register file memory, two registered read ports, one write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvm_regfile
    import tvm_pkg::*;
#(
    parameter int unsigned REG_COUNT = 16,
    localparam int unsigned IDX_W = $clog2(REG_COUNT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_a_idx,
    input  logic [IDX_W-1:0]  rd_b_idx,
    output logic [DATA_W-1:0] rd_a_data,
    output logic [DATA_W-1:0] rd_b_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0]    rdata_a_reg;
    logic [DATA_W-1:0]    rdata_b_reg;
    logic                 rvalid_a_reg;
    logic                 rvalid_b_reg;

    // storage and read data, old contents on a same-edge write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_a_reg <= mem[rd_a_idx];
            rdata_b_reg <= mem[rd_b_idx];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rvalid_a_reg <= 1'b0;
            rvalid_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_a_reg <= valid_reg[rd_a_idx];
                rvalid_b_reg <= valid_reg[rd_b_idx];
            end
        end
    end

    assign rd_a_data = rvalid_a_reg ? rdata_a_reg : '0;
    assign rd_b_data = rvalid_b_reg ? rdata_b_reg : '0;

endmodule

// ===== src/tvm_decode.sv =====
// ----------------------------------------------------------------------------
// tvm_decode
// input stage, reduces register indices modulo the register count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvm_decode
    import tvm_pkg::*;
#(
    parameter int unsigned REG_COUNT = 16,
    localparam int unsigned IDX_W = $clog2(REG_COUNT)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             instr_valid,
    output logic             instr_ready,
    input  instr_t           instr,
    output logic             iss_valid,
    input  logic             iss_ready,
    output instr_t           iss,
    output logic [IDX_W-1:0] wr_idx,
    output logic [IDX_W-1:0] rd_a_idx,
    output logic [IDX_W-1:0] rd_b_idx
);

    // floor reciprocals, quotient estimate is exact or one low
    localparam logic [ARG1_W-1:0] RECIP1 = ARG1_W'((64'(1) << ARG1_W) / REG_COUNT);
    localparam logic [ARG2_W-1:0] RECIP2 = ARG2_W'((64'(1) << ARG2_W) / REG_COUNT);
    localparam logic [ARG3_W-1:0] RECIP3 = ARG3_W'((64'(1) << ARG3_W) / REG_COUNT);

    logic                  valid_reg;
    instr_t                instr_reg;
    logic [2*ARG1_W-1:0]   prod1_reg;
    logic [2*ARG2_W-1:0]   prod2_reg;
    logic [2*ARG3_W-1:0]   prod3_reg;
    logic [IDX_W-1:0]      idx1;
    logic [IDX_W-1:0]      idx2;
    logic [IDX_W-1:0]      idx3;
    logic                  accept;

    function automatic logic [IDX_W-1:0] fold(input logic [31:0] x, input logic [31:0] q);
        logic [31:0] r;
        r = x - q * 32'(REG_COUNT);
        if (r >= 32'(REG_COUNT))
        begin
            r = r - 32'(REG_COUNT);
        end
        return r[IDX_W-1:0];
    endfunction

    assign accept      = instr_valid && instr_ready;
    assign iss_valid   = valid_reg;
    assign instr_ready = !valid_reg || iss_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (instr_ready)
        begin
            valid_reg <= instr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg <= instr;
            prod1_reg <= (2*ARG1_W)'(instr.first_arg) * (2*ARG1_W)'(RECIP1);
            prod2_reg <= (2*ARG2_W)'($unsigned(instr.second_arg)) * (2*ARG2_W)'(RECIP2);
            prod3_reg <= (2*ARG3_W)'(instr.third_arg) * (2*ARG3_W)'(RECIP3);
        end
    end

    always_comb
    begin
        idx1 = fold(32'(instr_reg.first_arg), 32'(prod1_reg[2*ARG1_W-1:ARG1_W]));
        idx2 = fold(32'($unsigned(instr_reg.second_arg)),
                    32'(prod2_reg[2*ARG2_W-1:ARG2_W]));
        idx3 = fold(32'(instr_reg.third_arg), 32'(prod3_reg[2*ARG3_W-1:ARG3_W]));
    end

    assign iss      = instr_reg;
    assign wr_idx   = idx1;
    // print reads the register named by the first argument
    assign rd_a_idx = (instr_reg.op == OP_PRINT) ? idx1 : idx2;
    assign rd_b_idx = idx3;

endmodule

// ===== src/tvm_exec.sv =====
// ----------------------------------------------------------------------------
// tvm_exec
// execute stage with counter, halt flag, write forwarding and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvm_exec
    import tvm_pkg::*;
#(
    parameter int unsigned REG_COUNT = 16,
    parameter int unsigned PC_WIDTH  = 16,
    localparam int unsigned IDX_W = $clog2(REG_COUNT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              iss_valid,
    output logic              iss_ready,
    input  instr_t            iss,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [IDX_W-1:0]  rd_a_idx,
    input  logic [IDX_W-1:0]  rd_b_idx,
    input  logic [DATA_W-1:0] rf_a,
    input  logic [DATA_W-1:0] rf_b,
    output logic              rf_we,
    output logic [IDX_W-1:0]  rf_waddr,
    output logic [DATA_W-1:0] rf_wdata,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

`include "toy_vm_execute_unit_top_macros.svh"

    logic                s_valid_reg;
    instr_t              s_instr_reg;
    logic [IDX_W-1:0]    s_wr_idx_reg;
    logic [IDX_W-1:0]    s_rd_a_idx_reg;
    logic [IDX_W-1:0]    s_rd_b_idx_reg;
    logic [PC_WIDTH-1:0] pc_reg;
    logic [PC_WIDTH-1:0] pc_next;
    logic                halt_reg;
    logic                halt_next;
    logic                fwd_valid_reg;
    logic [IDX_W-1:0]    fwd_idx_reg;
    logic [DATA_W-1:0]   fwd_data_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                fire;
    logic                take;
    logic [DATA_W-1:0]   opa;
    logic [DATA_W-1:0]   opb;
    logic                we;
    logic [DATA_W-1:0]   wdata;
    logic                pvalid;
    logic [DATA_W-1:0]   pval;

    assign fire      = s_valid_reg && (!out_valid_reg || result_ready);
    assign iss_ready = !s_valid_reg || fire;
    assign take      = iss_valid && iss_ready;

    // last write covers a read issued on the same edge
    assign opa = (fwd_valid_reg && fwd_idx_reg == s_rd_a_idx_reg) ? fwd_data_reg : rf_a;
    assign opb = (fwd_valid_reg && fwd_idx_reg == s_rd_b_idx_reg) ? fwd_data_reg : rf_b;

    always_comb
    begin
        pc_next   = pc_reg + PC_WIDTH'(1);
        halt_next = halt_reg;
        we        = 1'b0;
        wdata     = '0;
        pvalid    = 1'b0;
        pval      = '0;
        if (halt_reg)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            unique case (opcode_t'(s_instr_reg.op))
                OP_HALT:
                begin
                    halt_next = 1'b1;
                end
                OP_ADD:
                begin
                    we    = 1'b1;
                    wdata = opa + opb;
                end
                OP_SUB:
                begin
                    we    = 1'b1;
                    wdata = opa - opb;
                end
                OP_LOADI:
                begin
                    we    = 1'b1;
                    wdata = $unsigned(s_instr_reg.second_arg);
                end
                OP_MOVE:
                begin
                    we    = 1'b1;
                    wdata = opa;
                end
                OP_JUMP:
                begin
                    pc_next = PC_WIDTH'(s_instr_reg.first_arg);
                end
                OP_JNZ:
                begin
                    if (opa != '0)
                    begin
                        pc_next = PC_WIDTH'(s_instr_reg.first_arg);
                    end
                end
                OP_JZ:
                begin
                    if (opa == '0)
                    begin
                        pc_next = PC_WIDTH'(s_instr_reg.first_arg);
                    end
                end
                OP_PRINT:
                begin
                    pvalid = 1'b1;
                    pval   = opa;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rf_we    = fire && we;
    assign rf_waddr = s_wr_idx_reg;
    assign rf_wdata = wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (iss_ready)
            begin
                s_valid_reg <= iss_valid;
            end
            if (fire)
            begin
                pc_reg   <= pc_next;
                halt_reg <= halt_next;
            end
            if (rf_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_instr_reg    <= iss;
            s_wr_idx_reg   <= wr_idx;
            s_rd_a_idx_reg <= rd_a_idx;
            s_rd_b_idx_reg <= rd_b_idx;
        end
        if (rf_we)
        begin
            fwd_idx_reg  <= s_wr_idx_reg;
            fwd_data_reg <= wdata;
        end
        if (fire)
        begin
            out_reg.next_pc     <= NPC_W'(pc_next);
            out_reg.print_valid <= pvalid;
            out_reg.print_value <= $signed(pval);
            out_reg.halted      <= halt_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `TVM_ASSERT_SAME(a_no_write_halted, halt_reg, !rf_we, "register write after halt")
    `TVM_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg, "halt flag cleared")
    `TVM_ASSERT_NEXT(a_pc_held, fire && halt_reg, pc_reg == $past(pc_reg),
        "counter moved while halted")

endmodule

// ===== tb/tb_toy_vm_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// tb_toy_vm_execute_unit_top
// self-checking bench for the toy vm execute unit: directed corner beats,
// then weighted random programs, each result checked against an in-bench
// model of the register file, counter and halt flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_toy_vm_execute_unit_top;
    import tvm_pkg::*;

    localparam int unsigned REG_COUNT     = 16;
    localparam int unsigned PC_WIDTH      = 16;
    localparam int unsigned RANDOM_BEATS  = 875;
    localparam int unsigned MAX_WAIT      = 17;
    localparam int unsigned PRESSURE_AT   = 300;  // result count that starts the long hold
    localparam int unsigned PRESSURE_HOLD = 250;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // opcodes outside the defined set, decoded as nop by the unit
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd10;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;

    // ------------------------------------------------------------------------
    // machine model and in-order result check
    // ------------------------------------------------------------------------
    class exec_checker;
        logic [DATA_W-1:0]   regs [REG_COUNT];
        logic [PC_WIDTH-1:0] pc;
        logic                halted;
        result_t             expected_q [$];
        int unsigned         errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc     = '0;
            halted = 1'b0;
            errors = 0;
        endfunction

        // execute one accepted beat on the model and queue its result
        function void note_instr(instr_t ins);
            result_t             want;
            logic [PC_WIDTH-1:0] nxt;
            int unsigned         dst;
            int unsigned         src_a;
            int unsigned         src_b;
            dst   = ins.first_arg % REG_COUNT;
            src_a = $unsigned(ins.second_arg) % REG_COUNT;
            src_b = ins.third_arg % REG_COUNT;
            want  = '0;
            nxt   = pc + 1'b1;
            if (halted) begin
                nxt = pc;
            end
            else begin
                case (ins.op)
                    OP_HALT:  halted = 1'b1;
                    OP_ADD:   regs[dst] = regs[src_a] + regs[src_b];
                    OP_SUB:   regs[dst] = regs[src_a] - regs[src_b];
                    OP_LOADI: regs[dst] = ins.second_arg;
                    OP_MOVE:  regs[dst] = regs[src_a];
                    OP_JUMP:  nxt = PC_WIDTH'(ins.first_arg);
                    OP_JNZ:
                    begin
                        if (regs[src_a] != '0) nxt = PC_WIDTH'(ins.first_arg);
                    end
                    OP_JZ:
                    begin
                        if (regs[src_a] == '0) nxt = PC_WIDTH'(ins.first_arg);
                    end
                    OP_PRINT:
                    begin
                        want.print_valid = 1'b1;
                        want.print_value = regs[dst];
                    end
                    default: ;
                endcase
                pc = nxt;
            end
            want.next_pc = NPC_W'(nxt);
            want.halted  = halted;
            expected_q.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.next_pc !== want.next_pc) begin
                $error("next_pc expected %h actual %h", want.next_pc, got.next_pc);
                errors++;
            end
            if (got.print_valid !== want.print_valid) begin
                $error("print_valid expected %b actual %b",
                       want.print_valid, got.print_valid);
                errors++;
            end
            if (got.print_value !== want.print_value) begin
                $error("print_value expected %h actual %h",
                       want.print_value, got.print_value);
                errors++;
            end
            if (got.halted !== want.halted) begin
                $error("halted expected %b actual %b", want.halted, got.halted);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic    clk;
    logic    rst_n;
    logic    instr_valid;
    logic    instr_ready;
    instr_t  instr;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    exec_checker sb;
    int          send_run;   // remaining zero-gap beats in a sender burst
    int          recv_run;   // same for the receiver
    int unsigned received;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    toy_vm_execute_unit_top #(
        .REG_COUNT (REG_COUNT),
        .PC_WIDTH  (PC_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .instr        (instr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // wait length per beat: mostly 0..MAX_WAIT, with occasional bursts of
    // back-to-back beats so both full-rate and gapped traffic are seen
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic instr_t pack_instr(logic [OP_W-1:0] op, logic [ARG1_W-1:0] a1,
                                          logic [ARG2_W-1:0] a2, logic [ARG3_W-1:0] a3);
        instr_t ins;
        ins.op         = op;
        ins.first_arg  = a1;
        ins.second_arg = a2;
        ins.third_arg  = a3;
        return ins;
    endfunction

    // random program beat; the op mix keeps registers busy and lets jumps
    // see both zero and nonzero sources. halt is left out so the machine
    // keeps running until the closing sequence
    function automatic instr_t random_instr();
        logic [OP_W-1:0]   op;
        logic [ARG2_W-1:0] a2;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        a2   = $urandom;
        if (pick < 20) begin
            op = OP_LOADI;
            case ($urandom_range(0, 3))
                0: a2 = '0;
                1: a2 = $urandom_range(0, 3);
                default: ;
            endcase
        end
        else if (pick < 33) op = OP_ADD;
        else if (pick < 45) op = OP_SUB;
        else if (pick < 55) op = OP_MOVE;
        else if (pick < 61) op = OP_JUMP;
        else if (pick < 68) op = OP_JNZ;
        else if (pick < 75) op = OP_JZ;
        else if (pick < 90) op = OP_PRINT;
        else if (pick < 95) op = OP_NOP;
        else op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        return pack_instr(op, ARG1_W'($urandom_range(0, 16'hFFFF)), a2,
                          ARG3_W'($urandom_range(0, 15)));
    endfunction

    // one instruction beat: optional gap, then hold valid until taken
    task automatic send_instr(input instr_t ins);
        int gap;
        gap = draw_wait(send_run);
        if (gap > 0) begin
            instr_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        instr       = ins;
        instr_valid = 1'b1;
        @(posedge clk);
        while (!instr_ready) @(posedge clk);
        sb.note_instr(ins);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, plus one long hold that backs the
    // pipeline up into the instruction channel
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        result_ready = 1'b0;
        received     = 0;
        recv_run     = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = (received == PRESSURE_AT) ? PRESSURE_HOLD : draw_wait(recv_run);
            if (stall > 0) begin
                result_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready = 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            sb.check_result(result);
            received++;
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles without a beat on either channel
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (instr_valid && instr_ready) || (result_valid && result_ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("tb_toy_vm_execute_unit_top failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        sb          = new();
        send_run    = 0;
        rst_n       = 1'b0;
        instr_valid = 1'b0;
        instr       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes and 32-bit wrap in add and subtract
        send_instr(pack_instr(OP_LOADI, 16'h0000, 32'h7FFF_FFFF, 4'h0));
        send_instr(pack_instr(OP_LOADI, 16'hFFFF, 32'h8000_0000, 4'hF)); // r15
        send_instr(pack_instr(OP_LOADI, 16'h0001, 32'hFFFF_FFFF, 4'h0));
        send_instr(pack_instr(OP_LOADI, 16'h0002, 32'h0000_0001, 4'h0));
        send_instr(pack_instr(OP_ADD,   16'h0003, 32'h0000_0000, 4'h2)); // max + 1
        // source index taken from the low bits of a negative second_arg
        send_instr(pack_instr(OP_ADD,   16'h0004, 32'hFFFF_FFF1, 4'h2)); // -1 + 1
        send_instr(pack_instr(OP_SUB,   16'h0005, 32'h0000_000F, 4'h2)); // min - 1
        send_instr(pack_instr(OP_SUB,   16'h0006, 32'h0000_0002, 4'h1));
        send_instr(pack_instr(OP_MOVE,  16'h0017, 32'h7FFF_FFFF, 4'h0)); // r7 = r15
        send_instr(pack_instr(OP_PRINT, 16'hFFF7, 32'h0000_0000, 4'h0));
        send_instr(pack_instr(OP_PRINT, 16'h0004, 32'hFFFF_FFFF, 4'hF));
        send_instr(pack_instr(OP_NOP,   16'hFFFF, 32'hFFFF_FFFF, 4'hF));
        send_instr(pack_instr(OP_UNDEF_LO, 16'h1234, 32'h0000_0003, 4'h1));
        send_instr(pack_instr(OP_UNDEF_HI, 16'hFFFF, 32'hFFFF_FFFF, 4'hF));
        // top of the counter range, then advance wraps to zero
        send_instr(pack_instr(OP_JUMP,  16'hFFFF, 32'h0000_0000, 4'h0));
        send_instr(pack_instr(OP_NOP,   16'h0000, 32'h0000_0000, 4'h0));
        // conditional jumps taken and not taken
        send_instr(pack_instr(OP_JNZ,   16'h1234, 32'h0000_0004, 4'h0)); // r4 zero
        send_instr(pack_instr(OP_JNZ,   16'hABCD, 32'h0000_0001, 4'h0));
        send_instr(pack_instr(OP_JZ,    16'h8000, 32'h0000_0004, 4'h0));
        send_instr(pack_instr(OP_JZ,    16'h4321, 32'h0000_0001, 4'h0));
        send_instr(pack_instr(OP_PRINT, 16'h0005, 32'h0000_0000, 4'h0));

        repeat (RANDOM_BEATS) send_instr(random_instr());

        // halt, then beats that must leave the halted machine untouched
        send_instr(pack_instr(OP_HALT,  16'hFFFF, 32'hFFFF_FFFF, 4'hF));
        send_instr(pack_instr(OP_PRINT, 16'h0005, 32'h0000_0000, 4'h0));
        send_instr(pack_instr(OP_JUMP,  16'h5555, 32'h0000_0000, 4'h0));
        send_instr(pack_instr(OP_LOADI, 16'h0000, 32'h1234_5678, 4'h0));
        send_instr(pack_instr(OP_HALT,  16'h0000, 32'h0000_0000, 4'h0));
        instr_valid = 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_toy_vm_execute_unit_top passed");
        else
            $display("tb_toy_vm_execute_unit_top failed");
        $finish;
    end

endmodule
